/* design/htr_pkg.sv */
// shared types and constants for the html tag recognizer
// no dependencies; used by every design file

package htr_pkg;

   // width of the offset fields on the channels
   localparam int PORT_OFF_W = 32;
   // default number of significant offset bits
   localparam int OFFSET_BITS_DEF = 32;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_LINE  = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      PH_IDLE       = 6'b000001,
      PH_AFTER_LT   = 6'b000010,
      PH_NAME_FIRST = 6'b000100,
      PH_NAME       = 6'b001000,
      PH_ATTR       = 6'b010000,
      PH_ATTR_NAME  = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      AS_OPEN   = 3'd0,
      AS_WHITE  = 3'd1,
      AS_NAME   = 3'd2,
      AS_EQ     = 3'd3,
      AS_UNQ    = 3'd4,
      AS_SQ     = 3'd5,
      AS_DQ     = 3'd6,
      AS_CLOSER = 3'd7
   } attr_type;

   typedef struct packed {
      phase_type phase;
      attr_type  attr;
      logic      pend_slash;
      logic      wait_line;
      logic      single;
   } htr_state_type;

endpackage

/* design/htr_if.sv */
// valid/ready channel interfaces for the html tag recognizer
// depends on htr_pkg

interface htr_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        kind;
   logic [7:0]                        ch;
   logic [htr_pkg::PORT_OFF_W-1:0]    offset;
   logic [htr_pkg::PORT_OFF_W-1:0]    limit;
   logic                              single_line;

   modport source (output valid, kind, ch, offset, limit, single_line, input ready);
   modport sink (input valid, kind, ch, offset, limit, single_line, output ready);
endinterface

interface htr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              matched;
   logic [htr_pkg::PORT_OFF_W-1:0]    end_offset;

   modport source (output valid, matched, end_offset, input ready);
   modport sink (input valid, matched, end_offset, output ready);
endinterface

/* design/htr_in_stage.sv */
// input register of the html tag recognizer
// depends on htr_pkg and htr_req_if

module htr_in_stage #(
   parameter int OFF_W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   htr_req_if.sink              req_ch,
   input  logic                 advance,
   output logic                 item_valid,
   output htr_pkg::kind_type    item_kind,
   output logic [7:0]           item_ch,
   output logic [OFF_W-1:0]     item_off,
   output logic [OFF_W-1:0]     item_limit,
   output logic                 item_single
);
   import htr_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   kind_type          kind_ff;
   logic [7:0]        ch_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [OFF_W-1:0]  limit_ff;
   logic              single_ff;
   logic              take;

   // slot frees when empty or when its item moves on
   assign req_ch.ready = !reset && (!valid_ff || advance);
   assign take         = req_ch.valid && req_ch.ready;
   assign valid_in     = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff   <= kind_type'(req_ch.kind);
         ch_ff     <= req_ch.ch;
         off_ff    <= req_ch.offset[OFF_W-1:0];
         limit_ff  <= req_ch.limit[OFF_W-1:0];
         single_ff <= req_ch.single_line;
      end
   end

   assign item_valid  = valid_ff;
   assign item_kind   = kind_ff;
   assign item_ch     = ch_ff;
   assign item_off    = off_ff;
   assign item_limit  = limit_ff;
   assign item_single = single_ff;

endmodule

/* design/htr_step.sv */
// per-character next-state and decision logic of the html tag recognizer
// depends on htr_pkg

module htr_step #(
   parameter int OFF_W = 32
) (
   input  htr_pkg::htr_state_type          cur,
   input  logic [OFF_W-1:0]                cur_limit,
   input  htr_pkg::kind_type               kind,
   input  logic [7:0]                      ch,
   input  logic [OFF_W-1:0]                off,
   input  logic                            single_line,
   output htr_pkg::htr_state_type          nxt,
   output logic                            load_limit,
   output logic                            res_valid,
   output logic                            res_matched,
   output logic [htr_pkg::PORT_OFF_W-1:0]  res_end
);
   import htr_pkg::*;

   localparam logic [7:0] C_GT = 8'h3E;
   localparam logic [7:0] C_LT = 8'h3C;
   localparam logic [7:0] C_EQ = 8'h3D;
   localparam logic [7:0] C_SL = 8'h2F;
   localparam logic [7:0] C_DQ = 8'h22;
   localparam logic [7:0] C_SQ = 8'h27;
   localparam logic [7:0] C_BT = 8'h60;
   localparam logic [7:0] C_US = 8'h5F;
   localparam logic [7:0] C_CO = 8'h3A;
   localparam logic [7:0] C_DT = 8'h2E;
   localparam logic [7:0] C_MI = 8'h2D;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_alpha(c) || (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09);
   endfunction

   function automatic logic is_white(input logic [7:0] c);
      return is_blank(c) || (c == 8'h0B) || (c == 8'h0C);
   endfunction

   function automatic logic is_value_stop(input logic [7:0] c);
      return (c == C_DQ) || (c == C_SQ) || (c == C_EQ) || (c == C_LT) ||
             (c == C_GT) || (c == C_BT);
   endfunction

   logic              fail;
   logic              close;
   logic              past_limit;
   logic [OFF_W-1:0]  off_next;

   assign past_limit = (off >= cur_limit);
   assign off_next   = off + {{(OFF_W-1){1'b0}}, 1'b1};

   always_comb begin
      attr_type s;
      logic     run;
      logic     skip;
      logic     may_close;

      nxt        = cur;
      load_limit = 1'b0;
      fail       = 1'b0;
      close      = 1'b0;
      s          = cur.attr;
      run        = 1'b0;
      skip       = 1'b0;
      may_close  = 1'b0;

      if (kind == KIND_START) begin
         nxt.phase      = PH_AFTER_LT;
         nxt.attr       = AS_OPEN;
         nxt.pend_slash = 1'b0;
         nxt.wait_line  = 1'b0;
         nxt.single     = single_line;
         load_limit     = 1'b1;
      end else if (cur.phase == PH_IDLE) begin
         // nothing armed
      end else if (cur.pend_slash) begin
         // a slash must be followed at once by the closing bracket
         nxt.pend_slash = 1'b0;
         if (kind == KIND_CHAR && ch == C_GT) begin
            close = 1'b1;
         end else begin
            fail = 1'b1;
         end
      end else if (kind == KIND_END) begin
         fail = 1'b1;
      end else if (cur.phase == PH_AFTER_LT || cur.phase == PH_NAME_FIRST) begin
         if (kind != KIND_CHAR) begin
            fail = 1'b1;
         end else if (cur.phase == PH_AFTER_LT && ch == C_SL) begin
            nxt.attr  = AS_CLOSER;
            nxt.phase = PH_NAME_FIRST;
         end else if (!is_alpha(ch)) begin
            fail = 1'b1;
         end else begin
            nxt.phase = PH_NAME;
         end
      end else if (kind == KIND_LINE) begin
         if (cur.single) begin
            fail = 1'b1;
         end else begin
            nxt.wait_line = 1'b0;
            if (cur.phase == PH_ATTR_NAME) begin
               s = AS_NAME;
            end
            if (s == AS_OPEN || s == AS_UNQ) begin
               s = AS_WHITE;
            end
            nxt.attr  = s;
            nxt.phase = PH_ATTR;
            fail      = past_limit;
         end
      end else if (cur.wait_line) begin
         // rest of the line is ignored
      end else if (ch == 8'h0D || ch == 8'h0A) begin
         if (cur.single) begin
            fail = 1'b1;
         end else begin
            nxt.wait_line = 1'b1;
         end
      end else begin
         run = 1'b1;
         if (cur.phase == PH_NAME) begin
            if (is_alnum(ch) || ch == C_MI) begin
               run = 1'b0;
            end else begin
               nxt.phase = PH_ATTR;
            end
         end else if (cur.phase == PH_ATTR_NAME) begin
            if (is_alnum(ch) || ch == C_US || ch == C_DT || ch == C_CO || ch == C_MI) begin
               run = 1'b0;
            end else begin
               nxt.phase = PH_ATTR;
            end
         end
      end

      // attribute walk
      if (run) begin
         if (s == AS_UNQ || s == AS_SQ || s == AS_DQ) begin
            if (s == AS_UNQ && (is_blank(ch) || is_value_stop(ch))) begin
               s        = AS_OPEN;
               nxt.attr = AS_OPEN;
            end else begin
               skip = 1'b1;
               if ((s == AS_SQ && ch == C_SQ) || (s == AS_DQ && ch == C_DQ)) begin
                  nxt.attr = AS_OPEN;
               end
            end
         end
         may_close = (s == AS_OPEN) || (s == AS_WHITE) || (s == AS_NAME) ||
                     (s == AS_CLOSER);
         if (!skip) begin
            if (is_white(ch)) begin
               if (s == AS_OPEN) begin
                  nxt.attr = AS_WHITE;
               end
            end else if (may_close && ch == C_GT) begin
               close = 1'b1;
            end else if (may_close && ch == C_SL) begin
               nxt.pend_slash = 1'b1;
            end else if ((s == AS_WHITE || s == AS_NAME) &&
                         (is_alpha(ch) || ch == C_US || ch == C_CO)) begin
               nxt.attr  = AS_NAME;
               nxt.phase = PH_ATTR_NAME;
            end else if (s == AS_NAME && ch == C_EQ) begin
               nxt.attr = AS_EQ;
            end else if (s == AS_EQ) begin
               if (ch == C_DQ) begin
                  nxt.attr = AS_DQ;
               end else if (ch == C_SQ) begin
                  nxt.attr = AS_SQ;
               end else if (!is_value_stop(ch)) begin
                  nxt.attr = AS_UNQ;
               end else begin
                  fail = 1'b1;
               end
            end else begin
               fail = 1'b1;
            end
         end
      end

      // a bracket at or past the limit fails
      if (close && past_limit) begin
         close = 1'b0;
         fail  = 1'b1;
      end

      if (fail || close) begin
         nxt.phase      = PH_IDLE;
         nxt.pend_slash = 1'b0;
         nxt.wait_line  = 1'b0;
      end

      res_valid   = fail || close;
      res_matched = close;
      res_end     = close ? PORT_OFF_W'(off_next) : '0;
   end

endmodule

/* design/html_tag_recognizer.sv */
// path: a req item is registered in the input register, decided there, and its result registered in the output register
// throughput: one item per cycle while the output is not stalled; the tag state updates once per item in a single pass
// back-pressure: the output register and the input register move together, so a stalled
// result holds at most one further item in the input register
// reset: synchronous, active high; recognizer idle, both registers empty, ready low in reset

module html_tag_recognizer #(
   parameter int OFFSET_BITS = htr_pkg::OFFSET_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   htr_req_if.sink   req_ch,
   htr_rsp_if.source rsp_ch
);
   import htr_pkg::*;

   // offsets are taken modulo both the channel width and the parameter
   localparam int OFF_W = (OFFSET_BITS < PORT_OFF_W) ? OFFSET_BITS : PORT_OFF_W;

   // input register outputs
   logic              item_valid;
   kind_type          item_kind;
   logic [7:0]        item_ch;
   logic [OFF_W-1:0]  item_off;
   logic [OFF_W-1:0]  item_limit;
   logic              item_single;

   // tag state
   htr_state_type     state_ff;
   htr_state_type     state_in;
   logic [OFF_W-1:0]  limit_ff;
   logic [OFF_W-1:0]  limit_in;

   // step outputs
   htr_state_type          step_nxt;
   logic                   step_load_limit;
   logic                   step_valid;
   logic                   step_matched;
   logic [PORT_OFF_W-1:0]  step_end;

   // output register
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic                   out_matched_ff;
   logic [PORT_OFF_W-1:0]  out_end_ff;

   // pipeline moves when the output register is free or being emptied
   logic advance;
   logic fire;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign fire    = advance && item_valid;

   htr_in_stage #(
      .OFF_W (OFF_W)
   ) u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_kind   (item_kind),
      .item_ch     (item_ch),
      .item_off    (item_off),
      .item_limit  (item_limit),
      .item_single (item_single)
   );

   htr_step #(
      .OFF_W (OFF_W)
   ) u_step (
      .cur         (state_ff),
      .cur_limit   (limit_ff),
      .kind        (item_kind),
      .ch          (item_ch),
      .off         (item_off),
      .single_line (item_single),
      .nxt         (step_nxt),
      .load_limit  (step_load_limit),
      .res_valid   (step_valid),
      .res_matched (step_matched),
      .res_end     (step_end)
   );

   // state only changes when an item leaves the input register
   assign state_in     = fire ? step_nxt : state_ff;
   assign limit_in     = (fire && step_load_limit) ? item_limit : limit_ff;
   assign out_valid_in = advance ? (item_valid && step_valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.attr       <= AS_OPEN;
         state_ff.pend_slash <= 1'b0;
         state_ff.wait_line  <= 1'b0;
         state_ff.single     <= 1'b0;
         limit_ff            <= '0;
         out_valid_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload, loaded with each decision
   always_ff @(posedge clock) begin
      if (fire && step_valid) begin
         out_matched_ff <= step_matched;
         out_end_ff     <= step_end;
      end
   end

   assign rsp_ch.valid      = out_valid_ff && !reset;
   assign rsp_ch.matched    = out_matched_ff;
   assign rsp_ch.end_offset = out_end_ff;

endmodule

/* design/htr_checker.sv */
// port-level checks for the html tag recognizer
// depends on htr_pkg; bound to html_tag_recognizer at the end of this file

module htr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_matched,
   input logic [htr_pkg::PORT_OFF_W-1:0]  rsp_end_offset
);
   import htr_pkg::*;

   // a rejected tag carries no end offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_end_offset == '0)
      else $error("fail result with nonzero end offset");

   // a match ends past a bracket below the limit, so its end is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_end_offset != '0)
      else $error("match result with zero end offset");

   // a new result follows a req transfer that passed through the input register and then the output register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching request transfer");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched) &&
                                  $stable(rsp_end_offset))
      else $error("stalled result changed");

endmodule

bind html_tag_recognizer htr_checker u_htr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_matched    (rsp_ch.matched),
   .rsp_end_offset (rsp_ch.end_offset)
);

/* verif/tag_verdict_checker.sv */
// passive checker for the html tag recognizer: watches both channels, predicts each tag verdict
// depends on htr_pkg and on the htr_req_if / htr_rsp_if interfaces
`timescale 1ns / 1ps

module tag_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   htr_req_if          req_mon,
   htr_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned match_total,
   output int unsigned reject_total
);
   import htr_pkg::*;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_GRAVE = 8'h60;

   typedef struct packed {
      logic        matched;
      logic [31:0] end_offset;
   } tag_verdict_type;

   tag_verdict_type verdict_q[$];

   // predicted recognizer state
   phase_type   tag_phase;
   attr_type    attr_st;
   logic        slash_wait;
   logic        line_wait;
   logic [31:0] lim_off;
   logic        one_line;

   int unsigned fails     = 0;
   int unsigned match_cnt = 0;
   int unsigned rejects   = 0;

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_alnum(input logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == " " || c == "\t";
   endfunction

   function automatic bit is_value_stop(input logic [7:0] c);
      return c == "\"" || c == "'" || c == "=" || c == "<" || c == ">" || c == CH_GRAVE;
   endfunction

   function automatic bit reject_tag(output tag_verdict_type v);
      tag_phase  = PH_IDLE;
      slash_wait = 1'b0;
      line_wait  = 1'b0;
      v = '0;
      return 1'b1;
   endfunction

   // closing '>' at offset gt; at or past the limit it rejects
   function automatic bit close_tag(input logic [31:0] gt, output tag_verdict_type v);
      if (gt >= lim_off) return reject_tag(v);
      tag_phase  = PH_IDLE;
      slash_wait = 1'b0;
      line_wait  = 1'b0;
      v.matched    = 1'b1;
      v.end_offset = gt + 32'd1;
      return 1'b1;
   endfunction

   // advances the predicted state by one item, returns 1 when a verdict is due
   function automatic bit recognize_step(input kind_type kind, input logic [7:0] c,
                                         input logic [31:0] off, input logic [31:0] lim,
                                         input logic sl, output tag_verdict_type v);
      attr_type s;
      bit       closable;
      v = '0;
      if (kind == KIND_START) begin
         tag_phase  = PH_AFTER_LT;
         attr_st    = AS_OPEN;
         slash_wait = 1'b0;
         line_wait  = 1'b0;
         lim_off    = lim;
         one_line   = sl;
         return 1'b0;
      end
      if (tag_phase == PH_IDLE) return 1'b0;
      if (slash_wait) begin
         slash_wait = 1'b0;
         if (kind == KIND_CHAR && c == ">") return close_tag(off, v);
         return reject_tag(v);
      end
      if (kind == KIND_END) return reject_tag(v);
      if (tag_phase == PH_AFTER_LT || tag_phase == PH_NAME_FIRST) begin
         if (kind != KIND_CHAR) return reject_tag(v);
         if (tag_phase == PH_AFTER_LT && c == "/") begin
            attr_st   = AS_CLOSER;
            tag_phase = PH_NAME_FIRST;
            return 1'b0;
         end
         if (!is_letter(c)) return reject_tag(v);
         tag_phase = PH_NAME;
         return 1'b0;
      end
      if (kind == KIND_LINE) begin
         if (one_line) return reject_tag(v);
         line_wait = 1'b0;
         if (tag_phase == PH_ATTR_NAME) attr_st = AS_NAME;
         tag_phase = PH_ATTR;
         if (attr_st == AS_OPEN || attr_st == AS_UNQ) attr_st = AS_WHITE;
         if (off >= lim_off) return reject_tag(v);
         return 1'b0;
      end
      if (line_wait) return 1'b0;
      if (c == CH_CR || c == CH_LF) begin
         if (one_line) return reject_tag(v);
         line_wait = 1'b1;
         return 1'b0;
      end
      if (tag_phase == PH_NAME) begin
         if (is_alnum(c) || c == "-") return 1'b0;
         tag_phase = PH_ATTR;
      end else if (tag_phase == PH_ATTR_NAME) begin
         if (is_alnum(c) || c == "_" || c == "." || c == ":" || c == "-") return 1'b0;
         tag_phase = PH_ATTR;
      end
      // attribute walk
      s = attr_st;
      if (s == AS_UNQ || s == AS_SQ || s == AS_DQ) begin
         if (s == AS_UNQ && (is_blank(c) || is_value_stop(c))) begin
            attr_st = AS_OPEN;
            s = AS_OPEN;
         end else begin
            if ((s == AS_SQ && c == "'") || (s == AS_DQ && c == "\"")) attr_st = AS_OPEN;
            return 1'b0;
         end
      end
      if (is_blank(c) || c == CH_VT || c == CH_FF) begin
         if (s == AS_OPEN) attr_st = AS_WHITE;
         return 1'b0;
      end
      closable = (s <= AS_NAME) || (s == AS_CLOSER);
      if (closable && c == ">") return close_tag(off, v);
      if (closable && c == "/") begin
         slash_wait = 1'b1;
         return 1'b0;
      end
      if ((s == AS_WHITE || s == AS_NAME) && (is_letter(c) || c == "_" || c == ":")) begin
         attr_st   = AS_NAME;
         tag_phase = PH_ATTR_NAME;
         return 1'b0;
      end
      if (s == AS_NAME && c == "=") begin
         attr_st = AS_EQ;
         return 1'b0;
      end
      if (s == AS_EQ) begin
         if (c == "\"") attr_st = AS_DQ;
         else if (c == "'") attr_st = AS_SQ;
         else if (!is_value_stop(c)) attr_st = AS_UNQ;
         else return reject_tag(v);
         return 1'b0;
      end
      return reject_tag(v);
   endfunction

   always @(posedge clock) begin
      tag_verdict_type want;
      if (reset) begin
         tag_phase  = PH_IDLE;
         attr_st    = AS_OPEN;
         slash_wait = 1'b0;
         line_wait  = 1'b0;
         lim_off    = '0;
         one_line   = 1'b0;
         verdict_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_q.size() == 0) begin
               $error("result with no tag verdict pending: matched %0b end_offset %0h",
                      rsp_mon.matched, rsp_mon.end_offset);
               fails++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_mon.matched !== want.matched) begin
                  $error("matched: expected %0b, got %0b", want.matched, rsp_mon.matched);
                  fails++;
               end
               if (rsp_mon.end_offset !== want.end_offset) begin
                  $error("end_offset: expected %0h, got %0h", want.end_offset,
                         rsp_mon.end_offset);
                  fails++;
               end
               if (want.matched) match_cnt++;
               else rejects++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (recognize_step(kind_type'(req_mon.kind), req_mon.ch, req_mon.offset,
                               req_mon.limit, req_mon.single_line, want))
               verdict_q.push_back(want);
         end
      end
      fail_count   <= fails;
      pending      <= verdict_q.size();
      match_total  <= match_cnt;
      reject_total <= rejects;
   end

endmodule

/* verif/html_tag_recognizer_tb.sv */
// top-level testbench for html_tag_recognizer: clock, reset, tag stimulus and verdict
// depends on htr_pkg, htr_req_if / htr_rsp_if, the block itself and tag_verdict_checker
`timescale 1ns / 1ps

module html_tag_recognizer_tb;
   import htr_pkg::*;

   // random part is split evenly over the four traffic phases
   localparam int unsigned PHASE_ITEMS   = 425;
   // result passes the input and output registers after its transfer, wait a little longer than that
   localparam int unsigned SETTLE_CYCLES = 8;
   // receiver hold-off long enough to back the block up into its input
   localparam int unsigned LONG_STALL    = 250;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;

   // character pools for well-formed tags
   localparam string LETTERS    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
   localparam string NAME_REST  = "ABMXZabmxz0189-";
   localparam string ATTR_FIRST = "AZaqz_:";
   localparam string ATTR_REST  = "Aaz09_.:-";
   localparam string UNQUOTED   = "az09!#$%&()*+,-./;?@[]^_{|}~";
   localparam string SQ_TEXT    = "ab Z9\"=<>/\t";
   localparam string DQ_TEXT    = "ab Z9'=<>/\t";

   logic clock;
   logic reset;

   htr_req_if req_ch ();
   htr_rsp_if rsp_ch ();

   html_tag_recognizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned match_total;
   int unsigned reject_total;

   tag_verdict_checker verdict_chk (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .pending      (pending_results),
      .match_total  (match_total),
      .reject_total (reject_total)
   );

   // knobs shared between the sender and the receiver process
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned stall_orders  = 0;
   int unsigned items_sent    = 0;

   // tag under construction
   logic [31:0] cur_off;
   logic        tag_single;
   int unsigned tag_items;
   int unsigned corrupt_at;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("[html_tag_recognizer] ERROR");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off counted here when the sender orders one
   initial begin
      int unsigned hold_left;
      int unsigned seen_orders;
      hold_left   = 0;
      seen_orders = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_orders != seen_orders) begin
            seen_orders = stall_orders;
            hold_left   = LONG_STALL;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   function automatic logic [7:0] pick(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // one transfer on the request channel; valid stays up on return so that back-to-back
   // items never lower and raise it in the same step
   task automatic send_item(input kind_type kind, input logic [7:0] c, input logic [31:0] off,
                            input logic [31:0] lim, input logic sl);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.ch          <= c;
      req_ch.offset      <= off;
      req_ch.limit       <= lim;
      req_ch.single_line <= sl;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // fully random item: any kind, any byte, any offset and limit
   task automatic send_noise();
      send_item(kind_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom,
                $urandom, 1'($urandom_range(0, 1)));
   endtask

   // start item at '<'; limit and single-line flag are latched here only
   task automatic arm_tag(input logic [31:0] base, input logic [31:0] lim, input logic sl);
      tag_single = sl;
      tag_items  = 0;
      send_item(KIND_START, 8'($urandom_range(0, 255)), base, lim, sl);
      cur_off = base + 32'd1;
   endtask

   // item inside the tag body; an armed corruption point drops a noise item in first
   task automatic tag_item(input kind_type kind, input logic [7:0] c);
      tag_items++;
      if (tag_items == corrupt_at) send_noise();
      // limit and single_line are don't-care here, so toggle them freely
      send_item(kind, c, cur_off, $urandom, 1'($urandom_range(0, 1)));
      if (kind == KIND_CHAR) cur_off++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) tag_item(KIND_CHAR, s[i]);
   endtask

   // whitespace between tag parts, now and then a line break
   task automatic put_gap();
      if ($urandom_range(0, 4) == 0 && (!tag_single || $urandom_range(0, 3) == 0)) begin
         if ($urandom_range(0, 1) == 1) begin
            tag_item(KIND_CHAR, ($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
            // rest of the line is skipped by the block until the line start
            repeat ($urandom_range(0, 2)) tag_item(KIND_CHAR, 8'($urandom_range(0, 255)));
         end
         tag_item(KIND_LINE, 8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 3))
               0: tag_item(KIND_CHAR, " ");
               1: tag_item(KIND_CHAR, "\t");
               2: tag_item(KIND_CHAR, CH_VT);
               default: tag_item(KIND_CHAR, CH_FF);
            endcase
         end
      end
   endtask

   // mostly well-formed open or closing tag with random content; a fifth get a noise item
   // spliced in, and some end badly or not at all
   task automatic gen_tag();
      logic [31:0] base;
      logic [31:0] lim;
      logic        closer;
      int unsigned n_attr;
      base = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
         0: lim = $urandom;
         1: lim = base + $urandom_range(0, 12);
         2, 3: lim = base + 32'd400;
         default: lim = '1;
      endcase
      corrupt_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
      arm_tag(base, lim, ($urandom_range(0, 3) == 0));
      closer = ($urandom_range(0, 5) == 0);
      if (closer) tag_item(KIND_CHAR, "/");
      tag_item(KIND_CHAR, pick(LETTERS));
      repeat ($urandom_range(0, 4)) tag_item(KIND_CHAR, pick(NAME_REST));
      n_attr = closer ? 0 : $urandom_range(0, 3);
      repeat (n_attr) begin
         put_gap();
         tag_item(KIND_CHAR, pick(ATTR_FIRST));
         repeat ($urandom_range(0, 3)) tag_item(KIND_CHAR, pick(ATTR_REST));
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 3) == 0) put_gap();
            tag_item(KIND_CHAR, "=");
            if ($urandom_range(0, 3) == 0) put_gap();
            case ($urandom_range(0, 2))
               0: repeat ($urandom_range(1, 4)) tag_item(KIND_CHAR, pick(UNQUOTED));
               1: begin
                  tag_item(KIND_CHAR, "'");
                  repeat ($urandom_range(0, 4)) tag_item(KIND_CHAR, pick(SQ_TEXT));
                  tag_item(KIND_CHAR, "'");
               end
               default: begin
                  tag_item(KIND_CHAR, "\"");
                  repeat ($urandom_range(0, 4)) tag_item(KIND_CHAR, pick(DQ_TEXT));
                  tag_item(KIND_CHAR, "\"");
               end
            endcase
         end
      end
      if ($urandom_range(0, 2) == 0) put_gap();
      case ($urandom_range(0, 9))
         0: tag_item(KIND_END, 8'($urandom_range(0, 255)));
         // any byte: may leave the tag open until the next start drops it
         1: tag_item(KIND_CHAR, 8'($urandom_range(0, 255)));
         2, 3: put_text("/>");
         default: tag_item(KIND_CHAR, ">");
      endcase
   endtask

   // sender pause: drop valid and let every predicted verdict come out
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      // items that cause no verdict may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned phase_idx;
      int unsigned stop_at;
      bit          mid_pause_done;
      mid_pause_done = 1'b0;
      corrupt_at     = 0;
      tag_single     = 1'b0;
      tag_items      = 0;
      cur_off        = '0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_START;
      req_ch.ch          <= '0;
      req_ch.offset      <= '0;
      req_ch.limit       <= '0;
      req_ch.single_line <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: nothing armed yet, these are ignored
      send_item(KIND_CHAR, 8'hFF, '1, '1, 1'b1);
      send_item(KIND_END, 8'h00, '0, '0, 1'b0);
      // shortest self-closing tag, widest limit
      arm_tag(32'd0, '1, 1'b0);
      put_text("a/>");
      // closer decided at or past a zero limit
      arm_tag(32'd10, 32'd0, 1'b1);
      put_text("</b>");
      // start while active drops the first tag, then newline, skipped byte, late line start
      arm_tag(32'hFFFF_FFF0, '0, 1'b0);
      arm_tag(32'd100, 32'd200, 1'b0);
      put_text("x\n");
      tag_item(KIND_CHAR, 8'hFF);
      cur_off = 32'd300;
      tag_item(KIND_LINE, 8'h00);
      // single-line tag hit by a line start
      arm_tag(32'd0, '1, 1'b1);
      tag_item(KIND_CHAR, "p");
      tag_item(KIND_LINE, 8'h00);
      // slash not followed by '>'
      arm_tag(32'd40, '1, 1'b0);
      put_text("q/x");
      // match ending at the top of the offset range
      arm_tag(32'hFFFF_FFFC, '1, 1'b0);
      put_text("i>");
      wait_drained();

      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 74; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 74; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at) begin
            gen_tag();
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send_noise();
            // halfway through the full-rate phase: long output hold-off, sender keeps going
            if (phase_idx == 0 && stall_orders == 0 && items_sent + PHASE_ITEMS / 2 > stop_at)
               stall_orders++;
            // halfway through the mixed phase: pause until the pipe is empty
            if (phase_idx == 3 && !mid_pause_done && items_sent + PHASE_ITEMS / 2 > stop_at) begin
               wait_drained();
               mid_pause_done = 1'b1;
            end
         end
         wait_drained();
      end

      $display("covered %0d request transfers over full-rate, sender-idle, receiver-stall",
               items_sent);
      $display("and mixed phases with a long hold-off: %0d tags matched, %0d rejected",
               match_total, reject_total);
      if (fail_count == 0) begin
         $display("[html_tag_recognizer] OK");
      end else begin
         $display("[html_tag_recognizer] ERROR");
      end
      $finish;
   end

endmodule
